// File: hdl/cfa_pkg.sv
// Package: shared types, opcodes and helper functions for the folding ALU.
`default_nettype none
package cfa_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned WidthBits = 7;
  localparam int unsigned ShBits    = $clog2(DataWidth);
  localparam int unsigned NumCells  = DataWidth;

  typedef enum logic [4:0] {
    OpAdd  = 5'd0,  OpSub  = 5'd1,  OpMulu = 5'd2,  OpMuls = 5'd3,
    OpDivu = 5'd4,  OpDivs = 5'd5,  OpModu = 5'd6,  OpMods = 5'd7,
    OpShl  = 5'd8,  OpLsr  = 5'd9,  OpAsr  = 5'd10, OpAnd  = 5'd11,
    OpOr   = 5'd12, OpXor  = 5'd13, OpAndb = 5'd14, OpOrb  = 5'd15,
    OpEq   = 5'd16, OpNe   = 5'd17, OpLe   = 5'd18, OpGe   = 5'd19,
    OpLt   = 5'd20, OpGt   = 5'd21, OpB    = 5'd22, OpA    = 5'd23,
    OpBe   = 5'd24, OpAe   = 5'd25, OpNot  = 5'd26, OpNeg  = 5'd27,
    OpCast = 5'd28
  } op_e;

  typedef enum logic [1:0] {
    KindPass = 2'd0,
    KindMul  = 2'd1,
    KindQuo  = 2'd2,
    KindRem  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic                   neg;
    logic                   ok;
    logic [DataWidth-1:0]   mask;
    logic [DataWidth-1:0]   x;
    logic [DataWidth-1:0]   y;
    logic [DataWidth-1:0]   z;
  } stage_t;

  function automatic logic [WidthBits-1:0] clamp_width(logic [WidthBits-1:0] w);
    logic [WidthBits-1:0] r;
    r = w;
    if (w == '0) r = WidthBits'(1);
    else if (w > WidthBits'(DataWidth)) r = WidthBits'(DataWidth);
    return r;
  endfunction

  function automatic logic [DataWidth-1:0] mask_of(logic [WidthBits-1:0] w);
    logic [DataWidth-1:0] ones;
    ones = '1;
    return ones >> (WidthBits'(DataWidth) - w);
  endfunction

  function automatic logic [DataWidth-1:0] sext(logic [DataWidth-1:0] x,
                                               logic [WidthBits-1:0] w);
    logic [DataWidth-1:0] m;
    logic [ShBits-1:0]    idx;
    m   = mask_of(w);
    idx = ShBits'(w - WidthBits'(1));
    return (x & m) | (x[idx] ? ~m : '0);
  endfunction

  function automatic logic [DataWidth-1:0] mag(logic [DataWidth-1:0] x);
    return x[DataWidth-1] ? (('0) - x) : x;
  endfunction

endpackage
`default_nettype wire

// File: hdl/constant_folding_alu_unit.sv
// Top level: front stage, chain of multiply/divide cells and result register.
// Path from the accepting edge to result valid: front loads at accept,
// then 64 cells and the output register.
// Throughput: one item per cycle while out_ready_i is high; cells advance on ready_i.
// Ready passes combinationally through all stages, so bubbles are filled while stalled.
// Reset: asynchronous active-low, clears all stage valid bits; no other state.
`default_nettype none
module constant_folding_alu_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [4:0]                    func_i,
  input  wire logic [cfa_pkg::WidthBits-1:0] width_i,
  input  wire logic [cfa_pkg::DataWidth-1:0] left_operand_i,
  input  wire logic [cfa_pkg::DataWidth-1:0] right_operand_i,
  input  wire logic [cfa_pkg::WidthBits-1:0] source_width_i,
  input  wire logic                          source_signed_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [cfa_pkg::DataWidth-1:0]      value_out_o,
  output logic                               folded_o
);

  logic            valid_c [cfa_pkg::NumCells+1];
  logic            ready_c [cfa_pkg::NumCells+1];
  cfa_pkg::stage_t data_c  [cfa_pkg::NumCells+1];

  logic                          out_valid_q, out_ready;
  logic [cfa_pkg::DataWidth-1:0] value_q, value_d, sel;
  logic                          folded_q;

  cfa_front u_front (
    .clk_i,
    .rst_ni,
    .valid_i         (in_valid_i),
    .ready_o         (in_ready_o),
    .func_i,
    .width_i,
    .left_operand_i,
    .right_operand_i,
    .source_width_i,
    .source_signed_i,
    .valid_o         (valid_c[0]),
    .ready_i         (ready_c[0]),
    .data_o          (data_c[0])
  );

  for (genvar i = 0; i < cfa_pkg::NumCells; i++) begin : g_cell
    cfa_cell u_cell (
      .clk_i,
      .rst_ni,
      .valid_i (valid_c[i]),
      .ready_o (ready_c[i]),
      .data_i  (data_c[i]),
      .valid_o (valid_c[i+1]),
      .ready_i (ready_c[i+1]),
      .data_o  (data_c[i+1])
    );
  end

  assign out_ready                     = !out_valid_q || out_ready_i;
  assign ready_c[cfa_pkg::NumCells]    = out_ready;

  always_comb begin
    cfa_pkg::stage_t s;
    s       = data_c[cfa_pkg::NumCells];
    sel     = (s.kind == cfa_pkg::KindQuo) ? s.y : s.x;
    if (s.neg) sel = ('0) - sel;
    value_d = s.ok ? (sel & s.mask) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= valid_c[cfa_pkg::NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && valid_c[cfa_pkg::NumCells]) begin
      value_q  <= value_d;
      folded_q <= data_c[cfa_pkg::NumCells].ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_q;
  assign folded_o    = folded_q;

endmodule
`default_nettype wire

// File: hdl/cfa_front.sv
// Front stage: operand decode, simple operations and setup of the cell chain.
`default_nettype none
module cfa_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic [4:0]                  func_i,
  input  wire logic [cfa_pkg::WidthBits-1:0] width_i,
  input  wire logic [cfa_pkg::DataWidth-1:0] left_operand_i,
  input  wire logic [cfa_pkg::DataWidth-1:0] right_operand_i,
  input  wire logic [cfa_pkg::WidthBits-1:0] source_width_i,
  input  wire logic                        source_signed_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output cfa_pkg::stage_t                  data_o
);

  logic            valid_q;
  cfa_pkg::stage_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    logic [cfa_pkg::WidthBits-1:0] w, sw;
    logic [cfa_pkg::DataWidth-1:0] m, l, r, ul, ur, res, min_v;
    logic                          big;
    w     = cfa_pkg::clamp_width(width_i);
    sw    = cfa_pkg::clamp_width(source_width_i);
    m     = cfa_pkg::mask_of(w);
    l     = cfa_pkg::sext(left_operand_i, w);
    r     = cfa_pkg::sext(right_operand_i, w);
    ul    = l & m;
    ur    = r & m;
    min_v = {1'b1, {(cfa_pkg::DataWidth-1){1'b0}}};
    res   = '0;
    big   = r >= cfa_pkg::DataWidth'(cfa_pkg::DataWidth);
    data_d.kind = cfa_pkg::KindPass;
    data_d.neg  = 1'b0;
    data_d.ok   = 1'b1;
    data_d.mask = m;
    data_d.x    = '0;
    data_d.y    = '0;
    data_d.z    = '0;
    case (cfa_pkg::op_e'(func_i))
      cfa_pkg::OpAdd:  res = l + r;
      cfa_pkg::OpSub:  res = l - r;
      cfa_pkg::OpMulu, cfa_pkg::OpMuls: begin
        data_d.kind = cfa_pkg::KindMul;
        data_d.y    = r;
        data_d.z    = l;
      end
      cfa_pkg::OpDivu, cfa_pkg::OpModu: begin
        data_d.kind = (func_i == cfa_pkg::OpDivu) ? cfa_pkg::KindQuo : cfa_pkg::KindRem;
        data_d.ok   = ur != '0;
        data_d.y    = ul;
        data_d.z    = ur;
      end
      cfa_pkg::OpDivs, cfa_pkg::OpMods: begin
        data_d.kind = (func_i == cfa_pkg::OpDivs) ? cfa_pkg::KindQuo : cfa_pkg::KindRem;
        data_d.ok   = (r != '0) &&
                      !(w == cfa_pkg::WidthBits'(cfa_pkg::DataWidth) &&
                        l == min_v && r == '1);
        data_d.neg  = (func_i == cfa_pkg::OpDivs) ?
                      (l[cfa_pkg::DataWidth-1] ^ r[cfa_pkg::DataWidth-1]) :
                      l[cfa_pkg::DataWidth-1];
        data_d.y    = cfa_pkg::mag(l);
        data_d.z    = cfa_pkg::mag(r);
      end
      cfa_pkg::OpShl:  res = big ? '0 : (l << r[cfa_pkg::ShBits-1:0]);
      cfa_pkg::OpLsr:
        res = (ur >= cfa_pkg::DataWidth'(cfa_pkg::DataWidth)) ? '0 :
              (ul >> ur[cfa_pkg::ShBits-1:0]);
      cfa_pkg::OpAsr:
        res = big ? {cfa_pkg::DataWidth{l[cfa_pkg::DataWidth-1]}} :
              cfa_pkg::DataWidth'($signed(l) >>> r[cfa_pkg::ShBits-1:0]);
      cfa_pkg::OpAnd:  res = l & r;
      cfa_pkg::OpOr:   res = l | r;
      cfa_pkg::OpXor:  res = l ^ r;
      cfa_pkg::OpAndb: res = cfa_pkg::DataWidth'((l != '0) && (r != '0));
      cfa_pkg::OpOrb:  res = cfa_pkg::DataWidth'((l != '0) || (r != '0));
      cfa_pkg::OpEq:   res = cfa_pkg::DataWidth'(l == r);
      cfa_pkg::OpNe:   res = cfa_pkg::DataWidth'(l != r);
      cfa_pkg::OpLe:   res = cfa_pkg::DataWidth'($signed(l) <= $signed(r));
      cfa_pkg::OpGe:   res = cfa_pkg::DataWidth'($signed(l) >= $signed(r));
      cfa_pkg::OpLt:   res = cfa_pkg::DataWidth'($signed(l) < $signed(r));
      cfa_pkg::OpGt:   res = cfa_pkg::DataWidth'($signed(l) > $signed(r));
      cfa_pkg::OpB:    res = cfa_pkg::DataWidth'(ul < ur);
      cfa_pkg::OpA:    res = cfa_pkg::DataWidth'(ul > ur);
      cfa_pkg::OpBe:   res = cfa_pkg::DataWidth'(ul <= ur);
      cfa_pkg::OpAe:   res = cfa_pkg::DataWidth'(ul >= ur);
      cfa_pkg::OpNot:  res = ~left_operand_i;
      cfa_pkg::OpNeg:  res = ('0) - left_operand_i;
      cfa_pkg::OpCast:
        res = (source_signed_i && (w > sw)) ? cfa_pkg::sext(left_operand_i, sw) :
              left_operand_i;
      default:         data_d.ok = 1'b0;
    endcase
    if (data_d.kind == cfa_pkg::KindPass) data_d.x = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/cfa_cell.sv
// Chain cell: one shift-add multiply step or one restoring divide step; pass items go through.
`default_nettype none
module cfa_cell (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire cfa_pkg::stage_t data_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output cfa_pkg::stage_t data_o
);

  logic            valid_q;
  cfa_pkg::stage_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    logic [cfa_pkg::DataWidth:0] rs, t;
    data_d = data_i;
    rs     = {data_i.x, data_i.y[cfa_pkg::DataWidth-1]};
    t      = rs - {1'b0, data_i.z};
    case (data_i.kind)
      cfa_pkg::KindMul: begin
        data_d.x = data_i.x + (data_i.y[0] ? data_i.z : '0);
        data_d.y = data_i.y >> 1;
        data_d.z = data_i.z << 1;
      end
      cfa_pkg::KindQuo, cfa_pkg::KindRem: begin
        data_d.x = t[cfa_pkg::DataWidth] ? rs[cfa_pkg::DataWidth-1:0] :
                   t[cfa_pkg::DataWidth-1:0];
        data_d.y = {data_i.y[cfa_pkg::DataWidth-2:0], !t[cfa_pkg::DataWidth]};
      end
      default: data_d = data_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

// File: dv/tb_constant_folding_alu_unit.sv
// Testbench for the constant folding ALU: directed and random items checked against a predictor.
`default_nettype none
module tb_constant_folding_alu_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCycles = 400000;
  localparam logic [4:0]  OpFirstUnknown = 5'd29;
  localparam logic [4:0]  OpLastUnknown  = 5'd31;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [4:0]  func_i = '0;
  logic [6:0]  width_i = 7'd1;
  logic [63:0] left_operand_i = '0;
  logic [63:0] right_operand_i = '0;
  logic [6:0]  source_width_i = 7'd1;
  logic        source_signed_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] value_out_o;
  logic        folded_o;

  typedef struct packed {
    logic [63:0] value;
    logic        folded;
  } fold_t;

  fold_t       fold_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          stall_on = 1'b1;

  constant_folding_alu_unit u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned eff_w(logic [6:0] w);
    if (w == 0) return 1;
    if (w > 64) return 64;
    return 32'(w);
  endfunction

  function automatic logic [63:0] wmask(int unsigned w);
    return {64{1'b1}} >> (64 - w);
  endfunction

  function automatic logic [63:0] sx(logic [63:0] x, int unsigned w);
    logic [63:0] m;
    m = wmask(w);
    x &= m;
    if (x[w-1]) x |= ~m;
    return x;
  endfunction

  function automatic fold_t fold_op(logic [4:0] f, logic [6:0] wi, logic [63:0] a,
                                    logic [63:0] b, logic [6:0] swi, logic ss);
    int unsigned w, sw;
    logic [63:0] m, l, r, ul, ur, res, ma, mb, q;
    logic ok;
    fold_t o;
    w = eff_w(wi);
    sw = eff_w(swi);
    m = wmask(w);
    l = sx(a, w);
    r = sx(b, w);
    ul = l & m;
    ur = r & m;
    res = '0;
    ok = 1'b1;
    ma = l[63] ? -l : l;
    mb = r[63] ? -r : r;
    case (f)
      cfa_pkg::OpAdd: res = l + r;
      cfa_pkg::OpSub: res = l - r;
      cfa_pkg::OpMulu: res = ul * ur;
      cfa_pkg::OpMuls: res = l * r;
      cfa_pkg::OpDivu: if (ur == 0) ok = 1'b0; else res = ul / ur;
      cfa_pkg::OpModu: if (ur == 0) ok = 1'b0; else res = ul % ur;
      cfa_pkg::OpDivs, cfa_pkg::OpMods: begin
        if (r == 0 || (w == 64 && l == 64'h8000_0000_0000_0000 && r == '1)) begin
          ok = 1'b0;
        end else if (f == cfa_pkg::OpDivs) begin
          q = ma / mb;
          res = (l[63] != r[63]) ? -q : q;
        end else begin
          q = ma % mb;
          res = l[63] ? -q : q;
        end
      end
      cfa_pkg::OpShl: res = (r >= 64) ? '0 : l << r[5:0];
      cfa_pkg::OpLsr: res = (ur >= 64) ? '0 : ul >> ur[5:0];
      cfa_pkg::OpAsr: res = (r >= 64) ? {64{l[63]}} : 64'($signed(l) >>> r[5:0]);
      cfa_pkg::OpAnd: res = l & r;
      cfa_pkg::OpOr: res = l | r;
      cfa_pkg::OpXor: res = l ^ r;
      cfa_pkg::OpAndb: res = 64'(l != 0 && r != 0);
      cfa_pkg::OpOrb: res = 64'(l != 0 || r != 0);
      cfa_pkg::OpEq: res = 64'(l == r);
      cfa_pkg::OpNe: res = 64'(l != r);
      cfa_pkg::OpLe: res = 64'($signed(l) <= $signed(r));
      cfa_pkg::OpGe: res = 64'($signed(l) >= $signed(r));
      cfa_pkg::OpLt: res = 64'($signed(l) < $signed(r));
      cfa_pkg::OpGt: res = 64'($signed(l) > $signed(r));
      cfa_pkg::OpB: res = 64'(ul < ur);
      cfa_pkg::OpA: res = 64'(ul > ur);
      cfa_pkg::OpBe: res = 64'(ul <= ur);
      cfa_pkg::OpAe: res = 64'(ul >= ur);
      cfa_pkg::OpNot: res = ~a;
      cfa_pkg::OpNeg: res = -a;
      cfa_pkg::OpCast: res = (ss && w > sw) ? sx(a, sw) : a;
      default: ok = 1'b0;
    endcase
    o.value = ok ? (res & m) : '0;
    o.folded = ok;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  task automatic send_item(logic [4:0] f, logic [6:0] w, logic [63:0] a, logic [63:0] b,
                           logic [6:0] sw, logic s);
    int unsigned gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    width_i <= w;
    left_operand_i <= a;
    right_operand_i <= b;
    source_width_i <= sw;
    source_signed_i <= s;
    fold_q.push_back(fold_op(f, w, a, b, sw, s));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [63:0] rand_val(int unsigned w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = 64'(1) << (w - 1);
      3: v = 64'($urandom_range(0, 8));
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic [63:0] mn;
    mn = 64'h8000_0000_0000_0000;
    send_item(cfa_pkg::OpAdd, 7'd64, '1, 64'd1, 7'd1, 1'b0);
    send_item(cfa_pkg::OpDivu, 7'd8, 64'd5, 64'h100, 7'd1, 1'b0);
    send_item(cfa_pkg::OpDivs, 7'd64, mn, '1, 7'd1, 1'b0);
    send_item(cfa_pkg::OpMods, 7'd64, mn, '1, 7'd1, 1'b0);
    send_item(cfa_pkg::OpDivs, 7'd8, 64'h80, 64'hff, 7'd1, 1'b0);
    send_item(cfa_pkg::OpMods, 7'd8, 64'h80, 64'hff, 7'd1, 1'b0);
    send_item(cfa_pkg::OpDivs, 7'd16, 64'hfff9, 64'd2, 7'd1, 1'b0);
    send_item(cfa_pkg::OpMods, 7'd16, 64'hfff9, 64'd2, 7'd1, 1'b0);
    send_item(cfa_pkg::OpModu, 7'd64, 64'd7, '0, 7'd1, 1'b0);
    send_item(cfa_pkg::OpShl, 7'd64, 64'd1, 64'd64, 7'd1, 1'b0);
    send_item(cfa_pkg::OpAsr, 7'd64, mn, 64'd200, 7'd1, 1'b0);
    send_item(cfa_pkg::OpLsr, 7'd8, 64'h80, 64'hff, 7'd1, 1'b0);
    send_item(cfa_pkg::OpAsr, 7'd8, 64'h80, 64'hff, 7'd1, 1'b0);
    send_item(cfa_pkg::OpCast, 7'd64, 64'h80, '0, 7'd8, 1'b1);
    send_item(cfa_pkg::OpCast, 7'd4, 64'hff, '0, 7'd8, 1'b1);
    send_item(cfa_pkg::OpCast, 7'd64, 64'h80, '0, 7'd8, 1'b0);
    send_item(cfa_pkg::OpNeg, 7'd1, 64'd1, '0, 7'd1, 1'b0);
    send_item(cfa_pkg::OpNot, 7'd0, '0, '0, 7'd0, 1'b0);
    send_item(cfa_pkg::OpAdd, 7'd127, '1, '1, 7'd127, 1'b1);
    send_item(OpFirstUnknown, 7'd64, '1, '1, 7'd64, 1'b0);
    send_item(OpLastUnknown, 7'd1, '0, '0, 7'd1, 1'b0);
    send_item(cfa_pkg::OpLt, 7'd64, mn, '0, 7'd1, 1'b0);
    send_item(cfa_pkg::OpB, 7'd64, mn, '0, 7'd1, 1'b0);
  endtask

  task automatic test_random(int unsigned n);
    logic [6:0] w;
    logic [4:0] f;
    repeat (n) begin
      f = ($urandom_range(0, 30) == 0) ?
          5'($urandom_range(32'(OpFirstUnknown), 32'(OpLastUnknown))) :
          5'($urandom_range(0, 32'(cfa_pkg::OpCast)));
      w = ($urandom_range(0, 15) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
      send_item(f, w, rand_val(eff_w(w)), rand_val(eff_w(w)),
                ($urandom_range(0, 15) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64)),
                1'($urandom));
    end
  endtask

  task automatic test_drain();
    in_valid_i <= 1'b0;
    while (fold_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!stall_on) out_ready_i <= 1'b1;
    else if ($urandom_range(0, 49) == 0) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_ready_i <= ~out_ready_i;
    else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    fold_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (fold_q.size() == 0) begin
        report_mismatch("unexpected result", value_out_o, '0);
      end else begin
        want = fold_q.pop_front();
        if (value_out_o !== want.value) report_mismatch("value_out", value_out_o, want.value);
        if (folded_o !== want.folded) report_mismatch("folded", 64'(folded_o), 64'(want.folded));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain();
    test_random(600);
    stall_on = 1'b0;
    test_random(300);
    stall_on = 1'b1;
    test_drain();
    test_random(650);
    test_drain();
    repeat (150) @(posedge clk_i);
    if (error_count == 0 && fold_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
